// File: rtl/core/tks_pkg.sv
// Shared constants and command codes for the table key search block.
`default_nettype none

package tks_pkg;

	// Default number of table entries.
	localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;

	// Widths of one table word, of the reported position and of a command code.
	localparam int unsigned DATA_W     = 32;
	localparam int unsigned POSITION_W = 10;
	localparam int unsigned CMD_W      = 2;

	// Command codes carried on the cmd port.
	localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd0;
	localparam logic [CMD_W-1:0] CMD_APPEND = 2'd1;
	localparam logic [CMD_W-1:0] CMD_SEARCH = 2'd2;

endpackage : tks_pkg

`default_nettype wire

// File: rtl/core/table_key_search.sv
// Top level of the table key search block: entry memory, sequencer and result register.
`default_nettype none

// A table of signed 32-bit entries held in one synchronous memory.
// Commands enter on start when busy is low, with cmd and value.
// Clear and append take effect at the accepting edge and give no word;
// an append to a full table is dropped. The block stays ready afterwards.
// A search raises busy until its result word has been produced. The result
// (found, position) is shown for exactly one cycle with done high; the
// receiver cannot stall it, and busy is already low in that cycle.
// Linear mode (search_mode = 0) streams one memory read per cycle and
// compares the registered read word in the next cycle; the single memory
// read port sets this pace. Binary mode (search_mode = 1) passes each probe
// through ST_BPROBE, which issues the read, and then ST_BCMP, which
// compares and narrows the bounds.
// search_mode is written through search_mode_we / search_mode_wdata; the user
// must do so only while no search is running, as the block does not enforce
// it. Reset clears the entry count, the mode and the sequencer; the memory
// itself is not cleared, since only entries below the entry count are ever read.

module table_key_search #(
	parameter int unsigned TABLE_DEPTH = tks_pkg::DEFAULT_TABLE_DEPTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 start,
	output logic                                      busy,
	input  wire logic [tks_pkg::CMD_W-1:0]            cmd,
	input  wire logic signed [tks_pkg::DATA_W-1:0]    value,
	input  wire logic                                 search_mode_we,
	input  wire logic                                 search_mode_wdata,
	output logic                                      done,
	output logic                                      found,
	output logic [tks_pkg::POSITION_W-1:0]            position
);

	// Count width holds 0..TABLE_DEPTH, index width addresses the memory.
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
	localparam int unsigned IW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

	// Sequencer states.
	localparam logic [1:0] ST_IDLE   = 2'd0;
	localparam logic [1:0] ST_LIN    = 2'd1;
	localparam logic [1:0] ST_BPROBE = 2'd2;
	localparam logic [1:0] ST_BCMP   = 2'd3;

	logic signed [tks_pkg::DATA_W-1:0] mem [TABLE_DEPTH];

	logic [1:0]                        state_q, state_d;
	logic [CW-1:0]                     count_q;
	logic                              mode_q;
	logic signed [tks_pkg::DATA_W-1:0] key_q;
	logic [CW-1:0]                     idx_q, idx_d;
	logic [CW-1:0]                     low_q, low_d;
	logic [CW-1:0]                     hp1_q, hp1_d;
	logic                              rd_valid_s1, rd_valid_d;
	logic [IW-1:0]                     rd_idx_s1, rd_idx_d;
	logic signed [tks_pkg::DATA_W-1:0] rd_data_s1;

	logic                              accept;
	logic                              wr_en;
	logic                              rd_en;
	logic [IW-1:0]                     rd_addr;
	logic [CW-1:0]                     mid;
	logic                              finish;
	logic                              hit;
	logic [IW-1:0]                     hit_idx;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign wr_en  = accept && (cmd == tks_pkg::CMD_APPEND) && (count_q < CW'(TABLE_DEPTH));

	// Binary probe point: low + (high - low) / 2 with high = hp1 - 1, never negative here.
	assign mid = low_q + ((hp1_q - low_q - CW'(1)) >> 1);

	// Entry memory: one write port for appends, one registered read port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[count_q[IW-1:0]] <= value;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
	end

	// Search sequencer: next state, read requests and bound updates.
	always_comb begin
		state_d    = state_q;
		idx_d      = idx_q;
		low_d      = low_q;
		hp1_d      = hp1_q;
		rd_valid_d = 1'b0;
		rd_idx_d   = rd_idx_s1;
		rd_en      = 1'b0;
		rd_addr    = idx_q[IW-1:0];
		finish     = 1'b0;
		hit        = 1'b0;
		hit_idx    = rd_idx_s1;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && (cmd == tks_pkg::CMD_SEARCH)) begin
					idx_d   = '0;
					low_d   = '0;
					hp1_d   = count_q;
					state_d = mode_q ? ST_BPROBE : ST_LIN;
				end
			end
			ST_LIN: begin
				priority if (rd_valid_s1 && (rd_data_s1 == key_q)) begin
					finish  = 1'b1;
					hit     = 1'b1;
					state_d = ST_IDLE;
				end else if (idx_q == count_q) begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					rd_en      = 1'b1;
					rd_addr    = idx_q[IW-1:0];
					rd_valid_d = 1'b1;
					rd_idx_d   = idx_q[IW-1:0];
					idx_d      = idx_q + CW'(1);
				end
			end
			ST_BPROBE: begin
				if (low_q < hp1_q) begin
					rd_en    = 1'b1;
					rd_addr  = mid[IW-1:0];
					rd_idx_d = mid[IW-1:0];
					state_d  = ST_BCMP;
				end else begin
					finish  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			ST_BCMP: begin
				priority if (rd_data_s1 == key_q) begin
					finish  = 1'b1;
					hit     = 1'b1;
					state_d = ST_IDLE;
				end else if (rd_data_s1 < key_q) begin
					low_d   = CW'(rd_idx_s1) + CW'(1);
					state_d = ST_BPROBE;
				end else begin
					hp1_d   = CW'(rd_idx_s1);
					state_d = ST_BPROBE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control registers: sequencer state, read valid flag, done strobe, entry count and search mode.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			mode_q      <= 1'b0;
			rd_valid_s1 <= 1'b0;
			done        <= 1'b0;
		end else begin
			state_q     <= state_d;
			rd_valid_s1 <= rd_valid_d;
			done        <= finish;
			if (search_mode_we) begin
				mode_q <= search_mode_wdata;
			end
			if (accept && (cmd == tks_pkg::CMD_CLEAR)) begin
				count_q <= '0;
			end else if (wr_en) begin
				count_q <= count_q + CW'(1);
			end
		end
	end

	// Datapath registers: key, scan index, bounds, read index and the result word.
	always_ff @(posedge clk) begin
		if (accept) begin
			key_q <= value;
		end
		idx_q     <= idx_d;
		low_q     <= low_d;
		hp1_q     <= hp1_d;
		rd_idx_s1 <= rd_idx_d;
		if (finish) begin
			found    <= hit;
			position <= hit ? tks_pkg::POSITION_W'(hit_idx) : '0;
		end
	end

`ifndef NO_ASSERTIONS
	// A result word only appears once the sequencer has returned to idle.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (state_q == ST_IDLE))
		else $error("result word while a search is still running");

	// Each search yields a single one-cycle result word.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// The entry count never passes the table depth.
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	// A binary compare always follows a probe inside a nonempty interval.
	a_bin_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BCMP) |-> (low_q < hp1_q) && (CW'(rd_idx_s1) < count_q))
		else $error("binary probe outside the search bounds");
`endif

endmodule : table_key_search

`default_nettype wire
